@@ design/bba_pkg.sv @@
// Shared types and constants for the bitmap block allocator.
// Used by bba_ctrl, bba_datapath and bitmap_block_allocator.
package bba_pkg;

    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int WORD_WIDTH_DEF  = 32;
    localparam int INDEX_W         = 12;
    localparam int COUNT_W         = 13;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_TEST  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_DOUBLE   = 2'd3
    } status_t;

    typedef struct packed {
        action_t              action;
        logic [INDEX_W-1:0]   entry_index;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   granted_index;
        logic                 is_free;
    } rsp_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_SCAN,
        CTL_HOLD
    } ctl_state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic done;
    } ctl_sts_t;

endpackage

@@ design/bitmap_block_allocator.sv @@
// First-fit bitmap block allocator: one result per request.
// The scan reads map words in order from word 0 and ends at the word holding the first free
// entry, at the indexed word, or at the last word in range; the result passes res_reg, then rsp.
// A new request is taken only in idle, after the last result is loaded; one map word per cycle.
// Reset: map reads as all free through per-word valid bits, count_reg returns to 4096.
module bitmap_block_allocator #(
    parameter int MAX_ENTRIES = bba_pkg::MAX_ENTRIES_DEF,
    parameter int WORD_WIDTH  = bba_pkg::WORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  bba_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output bba_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bba_pkg::COUNT_W-1:0]   cfg_data
);
    import bba_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bba_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_wr   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

@@ design/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/bba_ctrl.sv @@
// Controller state machine for the bitmap block allocator.
// Depends on bba_pkg; drives bba_datapath through ctl_cmd_t.
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output bba_pkg::ctl_cmd_t  cmd,
    input  bba_pkg::ctl_sts_t  sts
);
    import bba_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        req_ready    = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = CTL_SCAN;
                end
            end
            CTL_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.done)
                begin
                    state_next = CTL_HOLD;
                end
            end
            CTL_HOLD:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

@@ design/bba_datapath.sv @@
// Datapath for the bitmap block allocator: free map, word scan, result registers.
// Depends on bba_pkg and bba_ram; steered by bba_ctrl through ctl_cmd_t.
module bba_datapath #(
    parameter int MAX_ENTRIES = bba_pkg::MAX_ENTRIES_DEF,
    parameter int WORD_WIDTH  = bba_pkg::WORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bba_pkg::req_t                 req,
    output bba_pkg::rsp_t                 rsp,
    input  logic                          cfg_wr,
    input  logic [bba_pkg::COUNT_W-1:0]   cfg_data,
    input  bba_pkg::ctl_cmd_t             cmd,
    output bba_pkg::ctl_sts_t             sts
);
    import bba_pkg::*;

    localparam int NWORDS = (MAX_ENTRIES + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW     = $clog2(WORD_WIDTH);
    localparam int CW_A   = $clog2(NWORDS * WORD_WIDTH + 1) + 1;
    localparam int CW     = (CW_A > COUNT_W + 1) ? CW_A : COUNT_W + 1;
    localparam logic [CW-1:0]   MAX_C   = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0]   WW_C    = CW'(WORD_WIDTH);
    localparam logic [WA-1:0]   LAST_W  = WA'(NWORDS - 1);
    localparam logic [WA:0]     NWORDS_C = (WA + 1)'(NWORDS);

    logic [COUNT_W-1:0]    count_reg;
    action_t               action_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [WA:0]           rd_addr_reg;
    logic [WA-1:0]         chk_addr_reg;
    logic [CW-1:0]         base_reg;
    logic                  vld_q_reg;
    logic [NWORDS-1:0]     word_valid_reg;
    rsp_t                  res_reg;
    rsp_t                  rsp_reg;

    logic [CW-1:0]         limit;
    logic [CW-1:0]         idx_ext;
    logic [CW-1:0]         rem;
    logic [CW-1:0]         off;
    logic [CW-1:0]         grant_sum;
    logic [WORD_WIDTH-1:0] ram_q;
    logic [WORD_WIDTH-1:0] word;
    logic [WORD_WIDTH-1:0] usable;
    logic [WORD_WIDTH-1:0] avail;
    logic [WORD_WIDTH-1:0] onehot;
    logic [WORD_WIDTH-1:0] wr_data;
    logic [BW-1:0]         bidx;
    logic [BW-1:0]         bsel;
    logic                  bit_val;
    logic                  in_word;
    logic                  in_range;
    logic                  last;
    logic                  no_more;
    logic                  done;
    logic                  wr_en;
    logic                  rd_en;
    logic [WA-1:0]         rd_addr;
    rsp_t                  res;

    assign limit   = (CW'(count_reg) > MAX_C) ? MAX_C : CW'(count_reg);
    assign idx_ext = CW'(index_reg);
    assign word    = vld_q_reg ? ram_q : '1;
    assign rem     = limit - base_reg;
    assign off     = idx_ext - base_reg;
    assign in_word = off < WW_C;
    assign bsel    = off[BW-1:0];
    assign in_range = idx_ext < limit;
    assign last    = chk_addr_reg == LAST_W;
    assign no_more = ((base_reg + WW_C) >= limit) || last;

    always_comb
    begin
        for (int b = 0; b < WORD_WIDTH; b++)
        begin
            usable[b] = (limit > base_reg) && (rem > CW'(b));
        end
    end

    assign avail  = word & usable;
    assign onehot = avail & (~avail + WORD_WIDTH'(1));

    always_comb
    begin
        bidx = '0;
        for (int b = 0; b < WORD_WIDTH; b++)
        begin
            if (onehot[b])
            begin
                bidx = bidx | BW'(b);
            end
        end
    end

    assign bit_val   = in_word ? word[bsel] : 1'b0;
    assign grant_sum = base_reg + CW'(bidx);

    always_comb
    begin
        done    = 1'b0;
        wr_en   = 1'b0;
        wr_data = word;
        res     = '0;
        res.status = ST_OK;
        unique case (action_reg)
            ACT_ALLOC:
            begin
                if (avail != '0)
                begin
                    done              = 1'b1;
                    wr_en             = 1'b1;
                    wr_data           = word & ~onehot;
                    res.granted_index = grant_sum[INDEX_W-1:0];
                end
                else if (no_more)
                begin
                    done       = 1'b1;
                    res.status = ST_NO_FREE;
                end
            end
            ACT_FREE:
            begin
                if (!in_range)
                begin
                    done       = 1'b1;
                    res.status = ST_RANGE;
                end
                else if (in_word)
                begin
                    done = 1'b1;
                    if (bit_val)
                    begin
                        res.status = ST_DOUBLE;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = word | (WORD_WIDTH'(1) << bsel);
                    end
                end
                else if (last)
                begin
                    done       = 1'b1;
                    res.status = ST_RANGE;
                end
            end
            ACT_TEST:
            begin
                if (!in_range)
                begin
                    done       = 1'b1;
                    res.status = ST_RANGE;
                end
                else if (in_word)
                begin
                    done        = 1'b1;
                    res.is_free = bit_val;
                end
                else if (last)
                begin
                    done       = 1'b1;
                    res.status = ST_RANGE;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        done  = done & cmd.scan;
        wr_en = wr_en & cmd.scan;
    end

    assign rd_en   = cmd.start || (cmd.scan && !done && (rd_addr_reg < NWORDS_C));
    assign rd_addr = cmd.start ? '0 : rd_addr_reg[WA-1:0];

    bba_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (NWORDS),
        .AW    (WA)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (chk_addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= COUNT_RESET;
            word_valid_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                count_reg <= cfg_data;
            end
            if (wr_en)
            begin
                word_valid_reg[chk_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            vld_q_reg <= word_valid_reg[rd_addr];
        end
        if (cmd.start)
        begin
            action_reg   <= req.action;
            index_reg    <= req.entry_index;
            rd_addr_reg  <= (WA + 1)'(1);
            chk_addr_reg <= '0;
            base_reg     <= '0;
        end
        else if (cmd.scan && !done)
        begin
            rd_addr_reg  <= rd_addr_reg + (WA + 1)'(1);
            chk_addr_reg <= rd_addr_reg[WA-1:0];
            base_reg     <= base_reg + WW_C;
        end
        if (done)
        begin
            res_reg <= res;
        end
        if (cmd.load_out)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp      = rsp_reg;
    assign sts.done = done;

endmodule
